### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, prop)
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)

`endif

`endif

### sv/swd_pkg.sv
// ----------------------------------------------------------------------------
// swd_pkg
// types, codes and helper functions of the serial wire debug host engine
// ----------------------------------------------------------------------------
`default_nettype none

package swd_pkg;

    localparam logic [1:0]  OP_TICK  = 2'd0;
    localparam logic [1:0]  OP_XFER  = 2'd1;
    localparam logic [1:0]  OP_LRST  = 2'd2;

    localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd15;
    localparam logic [15:0] LRST_CODE         = 16'hE79E;
    localparam logic [2:0]  ACK_OK            = 3'd1;

    localparam logic [7:0]  HDR_LAST_BIT  = 8'd7;
    localparam logic [7:0]  ACK_LAST_BIT  = 8'd2;
    localparam logic [7:0]  DATA_BITS     = 8'd32;
    localparam logic [7:0]  FAIL_LAST_BIT = 8'd31;
    localparam logic [7:0]  LRST_LAST_BIT = 8'd207;
    localparam logic [7:0]  LRST_CODE_LO  = 8'd64;
    localparam logic [7:0]  LRST_CODE_HI  = 8'd80;
    localparam logic [7:0]  LRST_ONES_HI  = 8'd144;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_HDR   = 8'b0000_0010,
        PH_ACK   = 8'b0000_0100,
        PH_RDATA = 8'b0000_1000,
        PH_RTAIL = 8'b0001_0000,
        PH_WDATA = 8'b0010_0000,
        PH_FAIL  = 8'b0100_0000,
        PH_LRST  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        access_port;
        logic        is_read;
        logic [1:0]  reg_addr;
        logic [31:0] write_data;
        logic        swdio_in;
    } swd_in_t;

    typedef struct packed {
        logic        swclk_pulse;
        logic        swdio_out;
        logic        swdio_oe;
        logic        busy_res;
        logic        done_res;
        logic        success;
        logic [2:0]  ack_code;
        logic [31:0] read_data;
        logic [7:0]  attempts_used;
    } swd_out_t;

    typedef struct packed {
        logic        access_port;
        logic        is_read;
        logic [1:0]  reg_addr;
        logic [31:0] write_data;
    } swd_req_t;

    // request header, bit 0 goes out first
    function automatic logic [7:0] header_bits(input swd_req_t req);
        logic par;
        par = req.access_port ^ req.is_read ^ req.reg_addr[0] ^ req.reg_addr[1];
        return {1'b1, 1'b0, par, req.reg_addr[1], req.reg_addr[0],
                req.is_read, req.access_port, 1'b1};
    endfunction

    // ones, select code, ones, then idle zeros
    function automatic logic line_reset_bit(input logic [7:0] idx);
        logic b;
        if (idx < LRST_CODE_LO) begin
            b = 1'b1;
        end else if (idx < LRST_CODE_HI) begin
            b = LRST_CODE[idx[3:0]];
        end else if (idx < LRST_ONES_HI) begin
            b = 1'b1;
        end else begin
            b = 1'b0;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

### sv/swd_bit_engine.sv
// ----------------------------------------------------------------------------
// swd_bit_engine
// per bit-period sequencer: header, ack, data, retry and line reset
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swd_bit_engine (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire swd_pkg::swd_in_t item,
    input  wire logic [7:0]      retry_limit,
    output swd_pkg::swd_out_t    result
);
    import swd_pkg::*;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [7:0]  bit_index_reg, bit_index_next, cur_bit;
    logic [31:0] shift_reg, shift_next;
    logic        parity_reg, parity_next;
    logic        line_dir_reg, line_dir_next;
    logic [7:0]  attempt_reg, attempt_next, cur_attempt;
    swd_req_t    req_reg, req_next;
    logic [31:0] captured_reg, captured_next;
    logic [2:0]  ack_reg, ack_next;

    logic        need_drive;
    logic [7:0]  hdr;
    logic [7:0]  lim;
    logic [2:0]  ack_base;

    // start of a transfer or line reset folds into the same bit period
    always_comb begin
        cur_phase   = phase_reg;
        cur_bit     = bit_index_reg;
        cur_attempt = attempt_reg;
        req_next    = req_reg;
        if (phase_reg == PH_IDLE) begin
            if (item.op == OP_XFER) begin
                req_next    = '{access_port: item.access_port, is_read: item.is_read,
                                reg_addr: item.reg_addr, write_data: item.write_data};
                cur_attempt = 8'd1;
                cur_phase   = PH_HDR;
                cur_bit     = '0;
            end else if (item.op == OP_LRST) begin
                cur_attempt = '0;
                cur_phase   = PH_LRST;
                cur_bit     = '0;
            end
        end
    end

    assign need_drive = !(cur_phase == PH_ACK || cur_phase == PH_RDATA);
    assign hdr        = header_bits(req_next);
    assign lim        = (retry_limit != '0) ? retry_limit : 8'd1;
    assign ack_base   = (cur_bit == '0) ? 3'd0 : ack_reg;

    always_comb begin
        phase_next     = cur_phase;
        bit_index_next = cur_bit;
        shift_next     = shift_reg;
        parity_next    = parity_reg;
        line_dir_next  = line_dir_reg;
        attempt_next   = cur_attempt;
        captured_next  = captured_reg;
        ack_next       = ack_reg;
        result         = '0;

        if (cur_phase != PH_IDLE) begin
            result.swclk_pulse = 1'b1;
            if (line_dir_reg != need_drive) begin
                // turnaround clock, line released
                line_dir_next = need_drive;
            end else if (need_drive) begin
                result.swdio_oe = 1'b1;
                case (cur_phase)
                    PH_HDR: begin
                        result.swdio_out = hdr[cur_bit[2:0]];
                        bit_index_next   = cur_bit + 8'd1;
                        if (cur_bit == HDR_LAST_BIT) begin
                            phase_next     = PH_ACK;
                            bit_index_next = '0;
                        end
                    end
                    PH_RTAIL: begin
                        phase_next       = PH_IDLE;
                        bit_index_next   = '0;
                        result.done_res  = 1'b1;
                        result.success   = 1'b1;
                    end
                    PH_WDATA: begin
                        if (cur_bit < DATA_BITS) begin
                            result.swdio_out = shift_reg[0];
                            shift_next       = {1'b0, shift_reg[31:1]};
                            parity_next      = parity_reg ^ shift_reg[0];
                            bit_index_next   = cur_bit + 8'd1;
                        end else if (cur_bit == DATA_BITS) begin
                            result.swdio_out = parity_reg;
                            bit_index_next   = cur_bit + 8'd1;
                        end else begin
                            phase_next      = PH_IDLE;
                            bit_index_next  = '0;
                            result.done_res = 1'b1;
                            result.success  = 1'b1;
                        end
                    end
                    PH_FAIL: begin
                        bit_index_next = cur_bit + 8'd1;
                        if (cur_bit == FAIL_LAST_BIT) begin
                            bit_index_next = '0;
                            if (cur_attempt >= lim) begin
                                phase_next      = PH_IDLE;
                                result.done_res = 1'b1;
                            end else begin
                                attempt_next = cur_attempt + 8'd1;
                                phase_next   = PH_HDR;
                            end
                        end
                    end
                    PH_LRST: begin
                        result.swdio_out = line_reset_bit(cur_bit);
                        if (cur_bit >= LRST_LAST_BIT) begin
                            phase_next      = PH_IDLE;
                            bit_index_next  = '0;
                            result.done_res = 1'b1;
                            result.success  = 1'b1;
                        end else begin
                            bit_index_next = cur_bit + 8'd1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end else if (cur_phase == PH_ACK) begin
                ack_next       = ack_base | ({2'b00, item.swdio_in} << cur_bit[1:0]);
                bit_index_next = cur_bit + 8'd1;
                if (cur_bit == ACK_LAST_BIT) begin
                    bit_index_next = '0;
                    shift_next     = '0;
                    parity_next    = 1'b0;
                    if (ack_next == ACK_OK) begin
                        if (req_next.is_read) begin
                            phase_next = PH_RDATA;
                        end else begin
                            shift_next = req_next.write_data;
                            phase_next = PH_WDATA;
                        end
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
            end else begin
                // read data shifts in from the top, LSB first on the wire
                if (cur_bit < DATA_BITS) begin
                    shift_next     = {item.swdio_in, shift_reg[31:1]};
                    parity_next    = parity_reg ^ item.swdio_in;
                    bit_index_next = cur_bit + 8'd1;
                end else begin
                    captured_next  = shift_reg;
                    bit_index_next = '0;
                    phase_next     = (item.swdio_in == parity_reg) ? PH_RTAIL : PH_FAIL;
                end
            end
        end

        result.busy_res      = (phase_next != PH_IDLE);
        result.ack_code      = ack_next;
        result.read_data     = captured_next;
        result.attempts_used = attempt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            parity_reg    <= 1'b0;
            line_dir_reg  <= 1'b0;
            attempt_reg   <= '0;
            captured_reg  <= '0;
            ack_reg       <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            parity_reg    <= parity_next;
            line_dir_reg  <= line_dir_next;
            attempt_reg   <= attempt_next;
            captured_reg  <= captured_next;
            ack_reg       <= ack_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            req_reg <= req_next;
        end
    end

    `ASSERT_IMPLY(a_idle_bit_zero, aclk, aresetn, phase_reg == PH_IDLE, bit_index_reg == '0)
    `ASSERT_IMPLY(a_ack_range, aclk, aresetn, phase_reg == PH_ACK, bit_index_reg <= ACK_LAST_BIT)
    `ASSERT_IMPLY(a_fail_attempt, aclk, aresetn, phase_reg == PH_FAIL, attempt_reg != '0)
    `ASSERT_IMPLY(a_oe_with_clock, aclk, aresetn, result.swdio_oe, result.swclk_pulse)

endmodule

`default_nettype wire

### sv/swd_host_transfer_engine_core.sv
// ----------------------------------------------------------------------------
// swd_host_transfer_engine_core
// serial wire debug host: one input beat per line bit period, one result beat
// ----------------------------------------------------------------------------
//  channel | ports                      | beat
//  --------+----------------------------+-----------------------------------
//  input   | s_valid s_ready s_data     | op, request fields, sampled line
//  result  | m_valid m_ready m_data     | clock/line drive, status, data
//  config  | cfg_valid cfg_ready cfg_data | retry limit, always ready
//
//  one beat per cycle while the result channel is ready; a result leaves
//  through the input register, then the result register fed by the bit sequencer
//  a full result register with m_ready low stalls the sequencer, and input
//  is still taken while the input register is empty or draining
//  reset is synchronous; retry limit comes up as 15, engine idle, line released
// ----------------------------------------------------------------------------
`default_nettype none

module swd_host_transfer_engine_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire swd_pkg::swd_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output swd_pkg::swd_out_t     m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [7:0]       cfg_data
);
    import swd_pkg::*;

    logic       in_valid_reg, in_valid_next;
    swd_in_t    in_data_reg;
    logic       out_valid_reg, out_valid_next;
    swd_out_t   out_data_reg;
    logic [7:0] retry_limit_reg;
    logic       advance;
    swd_out_t   step_result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    swd_bit_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .item        (in_data_reg),
        .retry_limit (retry_limit_reg),
        .result      (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            retry_limit_reg <= RETRY_LIMIT_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                retry_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

endmodule

`default_nettype wire
